FILE: sv/bitmap_8x8_transform_engine_top_defines.svh
// assertion helpers for the bitmap transform engine
`ifndef BITMAP_8X8_TRANSFORM_ENGINE_TOP_DEFINES_SVH
`define BITMAP_8X8_TRANSFORM_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define BMP_ASSERT_NOW(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define BMP_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/bmp_xform_pkg.sv
package bmp_xform_pkg;

   typedef enum logic [3:0] {
      OP_LOAD_ROW     = 4'd0,
      OP_READ_ROW     = 4'd1,
      OP_PEN_DOWN     = 4'd2,
      OP_PEN_MOVE     = 4'd3,
      OP_PEN_UP       = 4'd4,
      OP_FLIP_H       = 4'd5,
      OP_FLIP_V       = 4'd6,
      OP_ROT_CW       = 4'd7,
      OP_ROT_CCW      = 4'd8,
      OP_INVERT       = 4'd9,
      OP_SCROLL_UP    = 4'd10,
      OP_SCROLL_DOWN  = 4'd11,
      OP_SCROLL_LEFT  = 4'd12,
      OP_SCROLL_RIGHT = 4'd13
   } op_type;

   typedef struct packed {
      logic [3:0] operation;
      logic [2:0] row;
      logic [2:0] col;
      logic       in_grid;
      logic [7:0] row_data;
   } req_type;

   typedef struct packed {
      logic [7:0] row_bits;
      logic       drawing;
      logic       pen_colour;
   } rsp_type;

endpackage

FILE: sv/bitmap_8x8_transform_engine_top.sv
// One-bit SIDE x SIDE bitmap engine (SIDE = 8 by default). Each request beat carries one
// operation: load or read a row (column 0 in the top bit of row_data / row_bits), paint with
// a pen (down picks the colour opposite to the touched pixel and starts a stroke, move paints,
// up paints and ends the stroke), or transform the whole image in place (flip, rotate, invert,
// wrap-around scroll by one). Every request yields exactly one response beat with the read row
// (zero for other operations) and the stroke state after the operation. Throughput is one beat
// per cycle: the request lands in an input register, and the next image and the response are
// formed by a single pass of permutation logic into the image and response registers, so each
// beat passes through the input register and then the response register on its way out. A
// stalled response holds the beat in the input register, and with both full the request side
// stalls. The image clears at reset, at once.
`include "bitmap_8x8_transform_engine_top_defines.svh"

module bitmap_8x8_transform_engine_top #(
   parameter int SIDE = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bmp_xform_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bmp_xform_pkg::rsp_type rsp_data
);
   import bmp_xform_pkg::*;

   localparam int IDXW = $clog2(SIDE);

   // input register
   logic    s1_valid_ff;
   req_type s1_ff;

   // image and stroke state
   logic [SIDE-1:0] image_ff [SIDE];
   logic [SIDE-1:0] image_in [SIDE];
   logic            stroke_active_ff, active_in;
   logic            stroke_colour_ff, colour_in;

   // response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic            advance;
   logic            row_ok, col_ok, hit, pixel;
   logic [IDXW-1:0] row_idx, bit_idx;
   logic [7:0]      bits_in;

   // the held beat moves on when the response slot is empty or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // pixel addressing: column c lives at bit SIDE-1-c
   assign row_ok  = (32'(s1_ff.row) < 32'(SIDE));
   assign col_ok  = (32'(s1_ff.col) < 32'(SIDE));
   assign hit     = s1_ff.in_grid && row_ok && col_ok;
   assign row_idx = IDXW'(s1_ff.row);
   assign bit_idx = IDXW'(SIDE - 1) - IDXW'(s1_ff.col);
   assign pixel   = image_ff[row_idx][bit_idx];

   // next image, stroke state and response for the held beat
   always_comb begin
      image_in  = image_ff;
      active_in = stroke_active_ff;
      colour_in = stroke_colour_ff;
      bits_in   = '0;
      case (s1_ff.operation)
         OP_LOAD_ROW: begin
            if (row_ok) begin
               // bits above the grid width drop out, narrow rows zero-extend
               image_in[row_idx] = SIDE'(s1_ff.row_data);
            end
         end
         OP_READ_ROW: begin
            if (row_ok) begin
               bits_in = 8'(image_ff[row_idx]);
            end
         end
         OP_PEN_DOWN: begin
            if (hit) begin
               active_in                  = 1'b1;
               colour_in                  = ~pixel;
               image_in[row_idx][bit_idx] = ~pixel;
            end else begin
               active_in = 1'b0;
            end
         end
         OP_PEN_MOVE: begin
            if (stroke_active_ff && hit) begin
               image_in[row_idx][bit_idx] = stroke_colour_ff;
            end
         end
         OP_PEN_UP: begin
            if (stroke_active_ff && hit) begin
               image_in[row_idx][bit_idx] = stroke_colour_ff;
            end
            active_in = 1'b0;
         end
         OP_FLIP_H: begin
            for (int i = 0; i < SIDE; i++) begin
               for (int j = 0; j < SIDE; j++) begin
                  image_in[i][SIDE-1-j] = image_ff[i][j];
               end
            end
         end
         OP_FLIP_V: begin
            for (int i = 0; i < SIDE; i++) begin
               image_in[i] = image_ff[SIDE-1-i];
            end
         end
         OP_ROT_CW: begin
            // new (r, c) takes old (SIDE-1-c, r)
            for (int r = 0; r < SIDE; r++) begin
               for (int k = 0; k < SIDE; k++) begin
                  image_in[r][k] = image_ff[k][SIDE-1-r];
               end
            end
         end
         OP_ROT_CCW: begin
            // new (r, c) takes old (c, SIDE-1-r)
            for (int r = 0; r < SIDE; r++) begin
               for (int c = 0; c < SIDE; c++) begin
                  image_in[r][SIDE-1-c] = image_ff[c][r];
               end
            end
         end
         OP_INVERT: begin
            for (int i = 0; i < SIDE; i++) begin
               image_in[i] = ~image_ff[i];
            end
         end
         OP_SCROLL_UP: begin
            for (int i = 0; i < SIDE - 1; i++) begin
               image_in[i] = image_ff[i+1];
            end
            image_in[SIDE-1] = image_ff[0];
         end
         OP_SCROLL_DOWN: begin
            for (int i = 1; i < SIDE; i++) begin
               image_in[i] = image_ff[i-1];
            end
            image_in[0] = image_ff[SIDE-1];
         end
         OP_SCROLL_LEFT: begin
            for (int i = 0; i < SIDE; i++) begin
               image_in[i] = {image_ff[i][SIDE-2:0], image_ff[i][SIDE-1]};
            end
         end
         OP_SCROLL_RIGHT: begin
            for (int i = 0; i < SIDE; i++) begin
               image_in[i] = {image_ff[i][0], image_ff[i][SIDE-1:1]};
            end
         end
         default: begin
            // unused codes leave the state alone
         end
      endcase
      rsp_in.row_bits   = bits_in;
      rsp_in.drawing    = active_in;
      rsp_in.pen_colour = colour_in;
   end

   // input register: take a beat whenever the held one leaves or none is held
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_ff <= req_data;
      end
   end

   // image and stroke state commit together with the response
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE; i++) begin
            image_ff[i] <= '0;
         end
         stroke_active_ff <= 1'b0;
         stroke_colour_ff <= 1'b0;
      end else if (advance) begin
         image_ff         <= image_in;
         stroke_active_ff <= active_in;
         stroke_colour_ff <= colour_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // a beat leaving the input register always shows up as a response
   `BMP_ASSERT_NEXT(a_advance_gives_rsp, advance, rsp_valid, "advanced beat gave no response")
   // the offered response reports the stroke state it committed
   `BMP_ASSERT_NOW(a_rsp_matches_stroke, rsp_valid,
      (rsp_data.drawing == stroke_active_ff) && (rsp_data.pen_colour == stroke_colour_ff),
      "response stroke state differs from committed state")
   // both stages full and the output stalled must push back on the request side
   `BMP_ASSERT_NOW(a_full_pushes_back, s1_valid_ff && rsp_valid && rsp_stall, req_stall,
      "request taken while pipeline full")

endmodule
